@@ rtl/clt_pkg.sv @@
package clt_pkg;

    localparam logic [1:0] KIND_HEARTBEAT = 2'd0;
    localparam logic [1:0] KIND_OFFLINE   = 2'd1;
    localparam logic [1:0] KIND_CHECK     = 2'd2;

    localparam logic [2:0] STATUS_OFFLINE = 3'd6;

    localparam logic [31:0] THRESH_RESET  = 32'd35;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_NEW      = 3'd1,
        EV_UPDATED  = 3'd2,
        EV_OFFLINE  = 3'd3,
        EV_SILENT   = 3'd4,
        EV_FULL     = 3'd5,
        EV_NOTFOUND = 3'd6
    } t_event;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    // one table entry as held in memory
    typedef struct packed {
        logic [30:0] id;
        logic [31:0] heard;
    } t_entry;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [3:0]  slot;
        logic [30:0] entry_id;
        logic [2:0]  entry_status;
        logic [4:0]  client_count;
        logic        all_offline;
    } t_result;

endpackage

@@ rtl/clt_if.sv @@
interface clt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [30:0] client_id;
    logic [2:0]  status;
    logic        from_dc;
    logic [31:0] now;

    modport source (output valid, kind, client_id, status, from_dc, now, input ready);
    modport sink   (input valid, kind, client_id, status, from_dc, now, output ready);
endinterface

interface clt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [3:0]  slot;
    logic [30:0] entry_id;
    logic [2:0]  entry_status;
    logic [4:0]  client_count;
    logic        all_offline;

    modport source (output valid, event_res, slot, entry_id, entry_status, client_count,
                    all_offline, input ready);
    modport sink   (input valid, event_res, slot, entry_id, entry_status, client_count,
                    all_offline, output ready);
endinterface

@@ rtl/client_liveness_table_top.sv @@
// From accept to o_out.valid the table is scanned one slot a cycle, from slot 0 up to a hit
// or to the last entry; a removal then shifts the later entries down one slot; an item that
// touches no entry goes straight to the result. One item is handled at a time: a new one is
// accepted only after the last result has moved into the output register.
// Reset (synchronous, active low) empties the table, threshold 35; entry memory not cleared.
module client_liveness_table_top
    import clt_pkg::*;
#(
    parameter int MAX_CLIENTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clt_in_if.sink      i_in,
    clt_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    localparam int IW = $clog2(MAX_CLIENTS);

    logic [31:0] r_thresh;
    logic        r_out_valid;
    t_result     r_out;

    logic          w_out_free;
    logic          w_res_valid;
    t_result       w_res;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    t_entry        w_wdata;
    logic [IW-1:0] w_raddr;
    t_entry        w_rdata;

    assign w_out_free = !r_out_valid || o_out.ready;

    clt_ctrl #(
        .MAX_CLIENTS (MAX_CLIENTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_thresh    (r_thresh),
        .i_out_free  (w_out_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    clt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_CLIENTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= THRESH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            if (w_out_free) begin
                r_out_valid <= w_res_valid;
                if (w_res_valid) begin
                    r_out <= w_res;
                end
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_res    = r_out.event_res;
    assign o_out.slot         = r_out.slot;
    assign o_out.entry_id     = r_out.entry_id;
    assign o_out.entry_status = r_out.entry_status;
    assign o_out.client_count = r_out.client_count;
    assign o_out.all_offline  = r_out.all_offline;

`ifndef SYNTHESIS
    // an emptied table is only ever reported on a removal word
    a_alloff_removal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.all_offline |->
            (o_out.client_count == 5'd0)
            && ((o_out.event_res == EV_OFFLINE) || (o_out.event_res == EV_SILENT)))
        else $error("all_offline without an emptying removal");

    // no new word taken while a result is still held in the sequencer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !w_res_valid)
        else $error("input ready while a result is pending");

    // a finished result reaches the output register once there is room
    a_res_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && w_out_free |=> o_out.valid)
        else $error("result lost on its way to the output");

    // full and not-found words carry slot zero
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && ((o_out.event_res == EV_FULL) || (o_out.event_res == EV_NOTFOUND))
            |-> (o_out.slot == 4'd0))
        else $error("non-zero slot on a full or not-found word");
`endif

endmodule

@@ rtl/clt_ram.sv @@
module clt_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/clt_ctrl.sv @@
module clt_ctrl
    import clt_pkg::*;
#(
    parameter int MAX_CLIENTS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    clt_in_if.sink                         i_in,
    input  logic [31:0]                    i_thresh,
    input  logic                           i_out_free,
    output logic                           o_res_valid,
    output t_result                        o_res,
    output logic                           o_we,
    output logic [$clog2(MAX_CLIENTS)-1:0] o_waddr,
    output t_entry                         o_wdata,
    output logic [$clog2(MAX_CLIENTS)-1:0] o_raddr,
    input  t_entry                         i_rdata
);

    localparam int IW = $clog2(MAX_CLIENTS);
    localparam int CW = $clog2(MAX_CLIENTS + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_CLIENTS);

    t_state r_state, n_state;

    logic [1:0]    r_kind;
    logic [30:0]   r_id;
    logic [2:0]    r_status;
    logic          r_from_dc;
    logic [31:0]   r_now;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_iss;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic [CW-1:0] r_sh_rd;
    logic          r_sh_wvld;
    logic [IW-1:0] r_sh_wa;
    t_event        r_ev;
    logic [IW-1:0] r_slot;
    logic [30:0]   r_eid;
    logic [2:0]    r_est;
    logic          r_rm;

    logic w_accept;
    logic w_silent;
    logic w_hit;
    logic w_miss;
    logic w_sh_done;
    logic w_work;

    assign w_accept = i_in.valid && i_in.ready;

    // a timestamp later than now counts as no silence
    assign w_silent  = (r_now >= i_rdata.heard) && ((r_now - i_rdata.heard) > i_thresh);
    assign w_hit     = r_rd_vld && ((r_kind == KIND_CHECK) ? w_silent : (i_rdata.id == r_id));
    assign w_miss    = !r_rd_vld && (r_iss >= r_count);
    assign w_sh_done = !r_sh_wvld && (r_sh_rd >= r_count);

    assign w_work = ((i_in.kind == KIND_HEARTBEAT) && i_in.from_dc)
                 || ((i_in.kind == KIND_OFFLINE) && (i_in.status == STATUS_OFFLINE))
                 || (i_in.kind == KIND_CHECK);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_work ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_state = (r_kind == KIND_HEARTBEAT) ? S_DONE : S_SHIFT;
                end else if (w_miss) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (w_sh_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // outputs and memory port
    always_comb begin
        i_in.ready  = 1'b0;
        o_res_valid = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_rd_idx;
        o_wdata     = '{id: r_id, heard: r_now};
        o_raddr     = r_iss[IW-1:0];
        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
            end
            S_SCAN: begin
                if (r_kind == KIND_HEARTBEAT) begin
                    if (w_hit) begin
                        o_we = 1'b1;
                    end else if (w_miss && (r_count < MAX_C)) begin
                        o_we    = 1'b1;
                        o_waddr = r_count[IW-1:0];
                    end
                end
            end
            S_SHIFT: begin
                o_raddr = r_sh_rd[IW-1:0];
                o_we    = r_sh_wvld;
                o_waddr = r_sh_wa;
                o_wdata = i_rdata;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_res.event_res    = r_ev;
        o_res.slot         = 4'(r_slot);
        o_res.entry_id     = r_eid;
        o_res.entry_status = r_est;
        o_res.client_count = 5'(r_count);
        o_res.all_offline  = r_rm && (r_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_sh_wvld <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind    <= i_in.kind;
                        r_id      <= i_in.client_id;
                        r_status  <= i_in.status;
                        r_from_dc <= i_in.from_dc;
                        r_now     <= i_in.now;
                        r_iss     <= '0;
                        r_rd_vld  <= 1'b0;
                        r_ev      <= EV_NONE;
                        r_slot    <= '0;
                        r_eid     <= '0;
                        r_est     <= '0;
                        r_rm      <= 1'b0;
                    end
                end
                S_SCAN: begin
                    // one read issued per cycle, compare on the word in the cycle after its read
                    if (r_iss < r_count) begin
                        r_iss    <= r_iss + 1'b1;
                        r_rd_vld <= 1'b1;
                        r_rd_idx <= r_iss[IW-1:0];
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (w_hit) begin
                        r_slot    <= r_rd_idx;
                        r_sh_rd   <= CW'(r_rd_idx) + 1'b1;
                        r_sh_wvld <= 1'b0;
                        if (r_kind == KIND_HEARTBEAT) begin
                            r_ev  <= EV_UPDATED;
                            r_eid <= r_id;
                            r_est <= r_status;
                        end else if (r_kind == KIND_OFFLINE) begin
                            r_ev  <= EV_OFFLINE;
                            r_eid <= r_id;
                            r_est <= STATUS_OFFLINE;
                            r_rm  <= 1'b1;
                        end else begin
                            r_ev  <= EV_SILENT;
                            r_eid <= i_rdata.id;
                            r_est <= STATUS_OFFLINE;
                            r_rm  <= 1'b1;
                        end
                    end else if (w_miss) begin
                        if (r_kind == KIND_HEARTBEAT) begin
                            r_eid <= r_id;
                            r_est <= r_status;
                            if (r_count < MAX_C) begin
                                r_ev    <= EV_NEW;
                                r_slot  <= r_count[IW-1:0];
                                r_count <= r_count + 1'b1;
                            end else begin
                                r_ev <= EV_FULL;
                            end
                        end else if (r_kind == KIND_OFFLINE) begin
                            r_ev  <= EV_NOTFOUND;
                            r_eid <= r_id;
                            r_est <= r_status;
                        end
                    end
                end
                S_SHIFT: begin
                    // read slot k, write it to k-1 on the next cycle
                    if (r_sh_rd < r_count) begin
                        r_sh_rd   <= r_sh_rd + 1'b1;
                        r_sh_wvld <= 1'b1;
                        r_sh_wa   <= r_sh_rd[IW-1:0] - 1'b1;
                    end else begin
                        r_sh_wvld <= 1'b0;
                    end
                    if (w_sh_done) begin
                        r_count <= r_count - 1'b1;
                    end
                end
                S_DONE: begin
                    r_rd_vld <= r_rd_vld && r_from_dc;
                end
            endcase
        end
    end

endmodule
